// ===== rtl/vfpse_pkg.sv =====
`timescale 1ns / 1ps

package vfpse_pkg;

  localparam int unsigned MAX_VECTOR_LENGTH_DEF = 8;

  localparam logic [3:0] OP_VMOV     = 4'd0;
  localparam logic [3:0] OP_VMOV_IMM = 4'd1;
  localparam logic [3:0] OP_VADD     = 4'd2;
  localparam logic [3:0] OP_VSUB     = 4'd3;
  localparam logic [3:0] OP_VDIV     = 4'd4;
  localparam logic [3:0] OP_VMUL     = 4'd5;
  localparam logic [3:0] OP_VNMUL    = 4'd6;
  localparam logic [3:0] OP_VMLA     = 4'd7;
  localparam logic [3:0] OP_VNMLA    = 4'd8;
  localparam logic [3:0] OP_VMLS     = 4'd9;
  localparam logic [3:0] OP_VNMLS    = 4'd10;
  localparam logic [3:0] OP_VABS     = 4'd11;
  localparam logic [3:0] OP_VNEG     = 4'd12;
  localparam logic [3:0] OP_VSQRT    = 4'd13;
  localparam logic [3:0] NUM_OPS     = 4'd14;

  localparam logic [4:0] BANK_MASK_SP = 5'h18;
  localparam logic [4:0] BANK_MASK_DP = 5'h1C;
  localparam logic [4:0] WRAP_MASK_SP = 5'h07;
  localparam logic [4:0] WRAP_MASK_DP = 5'h03;
  localparam logic [31:0] SZ_BIT      = 32'h0000_0100;

  typedef struct packed {
    logic [3:0]  op_code;
    logic        double_precision;
    logic [4:0]  d_reg;
    logic [4:0]  n_reg;
    logic [4:0]  m_reg;
    logic [3:0]  vector_length;
    logic [1:0]  vector_stride;
    logic [63:0] imm_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [2:0]  element_index;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [4:0] bank_mask;
    logic [4:0] wrap_mask;
  } bank_ctl_t;

  function automatic logic [31:0] op_base(input logic [3:0] op);
    logic [31:0] w;
    w = '0;
    unique case (op)
      OP_VMOV:     w = 32'hEEB0_0A40;
      OP_VMOV_IMM: w = 32'hEEB0_0A00;
      OP_VADD:     w = 32'hEE30_0A00;
      OP_VSUB:     w = 32'hEE30_0A40;
      OP_VDIV:     w = 32'hEE80_0A00;
      OP_VMUL:     w = 32'hEE20_0A00;
      OP_VNMUL:    w = 32'hEE20_0A40;
      OP_VMLA:     w = 32'hEE00_0A00;
      OP_VNMLA:    w = 32'hEE10_0A40;
      OP_VMLS:     w = 32'hEE00_0A40;
      OP_VNMLS:    w = 32'hEE10_0A00;
      OP_VABS:     w = 32'hEEB0_0AC0;
      OP_VNEG:     w = 32'hEEB1_0A40;
      OP_VSQRT:    w = 32'hEEB1_0AC0;
      default:     w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/vfpse_encoder.sv =====
`timescale 1ns / 1ps

module vfpse_encoder (
  input  logic [3:0]  op,
  input  logic        dbl,
  input  logic [4:0]  d,
  input  logic [4:0]  n,
  input  logic [4:0]  m,
  input  logic [63:0] imm,
  output logic [31:0] word
);
  import vfpse_pkg::*;

  logic        uses_n;
  logic        is_imm;
  logic [31:0] w_d;
  logic [31:0] w_n;
  logic [31:0] w_m;
  logic [31:0] w_imm;

  assign uses_n = (op >= OP_VADD) && (op <= OP_VNMLS);
  assign is_imm = (op == OP_VMOV_IMM);

  always_comb begin
    if (dbl) begin
      w_d   = {9'd0, d[4], 6'd0, d[3:0], 12'd0} | SZ_BIT;
      w_n   = {12'd0, n[3:0], 8'd0, n[4], 7'd0};
      w_m   = {26'd0, m[4], 1'b0, m[3:0]};
      w_imm = {12'd0, imm[63], ~imm[62], imm[53:52], 12'd0, imm[51:48]};
    end else begin
      w_d   = {9'd0, d[0], 6'd0, d[4:1], 12'd0};
      w_n   = {12'd0, n[4:1], 8'd0, n[0], 7'd0};
      w_m   = {26'd0, m[0], 1'b0, m[4:1]};
      w_imm = {12'd0, imm[31], ~imm[30], imm[24:23], 12'd0, imm[22:19]};
    end
  end

  always_comb begin
    word = op_base(op) | w_d;
    if (is_imm) begin
      word = word | w_imm;
    end else begin
      word = word | w_m | (uses_n ? w_n : 32'd0);
    end
  end

endmodule

// ===== rtl/vfpse_reg_step.sv =====
`timescale 1ns / 1ps

module vfpse_reg_step (
  input  vfpse_pkg::bank_ctl_t ctl,
  input  logic [4:0]           cur,
  input  logic [1:0]           step,
  output logic [4:0]           nxt
);
  import vfpse_pkg::*;

  logic [4:0] sum;

  assign sum = cur + {3'd0, step};
  assign nxt = (sum & ctl.wrap_mask) | (cur & ctl.bank_mask);

endmodule

// ===== rtl/vfp_short_vector_expander.sv =====
`timescale 1ns / 1ps

// Expands one VFP short-vector instruction into its scalar encodings, one 32-bit
// word per element in element order, each shown on out_data for a single cycle
// with out_valid high; the receiver cannot stall, so every word must be taken
// as it appears. A transaction is accepted when start is high and busy is low.
// After acceptance the sequencer drives one element a cycle through a single
// encoder and three register steppers (d, n, m); the first word appears once
// the operands are registered and the word has passed the output register;
// busy falls in the last element so the next transaction can follow straight on.
// Unknown op codes and zero length produce no words. Lengths above
// MAX_VECTOR_LENGTH are saturated to it.
module vfp_short_vector_expander #(
  parameter int unsigned MAX_VECTOR_LENGTH = vfpse_pkg::MAX_VECTOR_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  vfpse_pkg::in_t  in_data,
  output logic            out_valid,
  output vfpse_pkg::out_t out_data
);
  import vfpse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  op_r;
  logic        dbl_r;
  logic [4:0]  d_r, n_r, m_r;
  logic [4:0]  d_nxt, n_nxt, m_nxt;
  logic [1:0]  stride_r;
  logic [1:0]  m_stride_r;
  logic [63:0] imm_r;
  logic [3:0]  len_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic [3:0]  len_max;
  logic [3:0]  len_sat;
  logic        accept_ok;
  logic        last_elem;
  logic [31:0] word;
  bank_ctl_t   ctl;
  bank_ctl_t   ctl_in;

  assign len_max   = 4'(MAX_VECTOR_LENGTH);
  assign len_sat   = (in_data.vector_length > len_max) ? len_max : in_data.vector_length;
  assign last_elem = ({1'b0, idx_r} + 4'd1) == len_r;
  assign busy      = (state_r == ST_RUN) && !last_elem;
  assign accept_ok = start && !busy && (in_data.op_code < NUM_OPS) && (len_sat != 4'd0);

  assign ctl.bank_mask    = dbl_r ? BANK_MASK_DP : BANK_MASK_SP;
  assign ctl.wrap_mask    = dbl_r ? WRAP_MASK_DP : WRAP_MASK_SP;
  assign ctl_in.bank_mask = in_data.double_precision ? BANK_MASK_DP : BANK_MASK_SP;
  assign ctl_in.wrap_mask = in_data.double_precision ? WRAP_MASK_DP : WRAP_MASK_SP;

  vfpse_encoder u_enc (
    .op   (op_r),
    .dbl  (dbl_r),
    .d    (d_r),
    .n    (n_r),
    .m    (m_r),
    .imm  (imm_r),
    .word (word)
  );

  vfpse_reg_step u_step_d (.ctl(ctl), .cur(d_r), .step(stride_r),   .nxt(d_nxt));
  vfpse_reg_step u_step_n (.ctl(ctl), .cur(n_r), .step(stride_r),   .nxt(n_nxt));
  vfpse_reg_step u_step_m (.ctl(ctl), .cur(m_r), .step(m_stride_r), .nxt(m_nxt));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_ok) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (last_elem) state_nxt = accept_ok ? ST_RUN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_ok) begin
      op_r       <= in_data.op_code;
      dbl_r      <= in_data.double_precision;
      d_r        <= in_data.d_reg;
      n_r        <= in_data.n_reg;
      m_r        <= in_data.m_reg;
      stride_r   <= in_data.vector_stride;
      m_stride_r <= ((in_data.m_reg & ctl_in.bank_mask) == 5'd0) ? 2'd0
                                                                 : in_data.vector_stride;
      imm_r      <= in_data.imm_bits;
      len_r      <= len_sat;
      idx_r      <= 3'd0;
    end else if (state_r == ST_RUN) begin
      d_r   <= d_nxt;
      n_r   <= n_nxt;
      m_r   <= m_nxt;
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      out_data_r.instr_word    <= word;
      out_data_r.element_index <= idx_r;
      out_data_r.last          <= last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_run_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> out_valid)
    else $error("element not emitted while running");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    accept_ok |=> ##1 (out_valid && (out_data.element_index == 3'd0)))
    else $error("first element index not zero");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=>
      (out_valid && (out_data.element_index == $past(out_data.element_index) + 3'd1)))
    else $error("element sequence broken");

  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (state_r == ST_RUN))
    else $error("busy outside run");

endmodule

// ===== bench/vfp_short_vector_expander_test.sv =====
`timescale 1ns / 1ps

module vfp_short_vector_expander_test;
  import vfpse_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_VECTOR_LENGTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 134;
  localparam int unsigned QUIET_TAIL   = 30;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  class scalar_word_tracker;
    out_t        expected_words[$];
    int unsigned errors;
    logic [3:0]  element_count;
    logic [4:0]  current_d;
    logic [4:0]  current_n;
    logic [4:0]  current_m;

    function new();
      errors        = 0;
      element_count = '0;
      current_d     = '0;
      current_n     = '0;
      current_m     = '0;
    endfunction

    task report(input string what);
      $display("mismatch at cycle edge %0t: %s", $realtime, what);
      errors++;
    endtask

    function logic [31:0] base_word(input logic [3:0] op);
      logic [31:0] w;
      w = '0;
      case (op)
        OP_VMOV:     w = 32'hEEB0_0A40;
        OP_VMOV_IMM: w = 32'hEEB0_0A00;
        OP_VADD:     w = 32'hEE30_0A00;
        OP_VSUB:     w = 32'hEE30_0A40;
        OP_VDIV:     w = 32'hEE80_0A00;
        OP_VMUL:     w = 32'hEE20_0A00;
        OP_VNMUL:    w = 32'hEE20_0A40;
        OP_VMLA:     w = 32'hEE00_0A00;
        OP_VNMLA:    w = 32'hEE10_0A40;
        OP_VMLS:     w = 32'hEE00_0A40;
        OP_VNMLS:    w = 32'hEE10_0A00;
        OP_VABS:     w = 32'hEEB0_0AC0;
        OP_VNEG:     w = 32'hEEB1_0A40;
        OP_VSQRT:    w = 32'hEEB1_0AC0;
        default:     w = '0;
      endcase
      return w;
    endfunction

    function logic [31:0] encode(input logic [3:0] op, input logic dbl,
                                 input logic [4:0] d, input logic [4:0] n,
                                 input logic [4:0] m, input logic [63:0] imm);
      logic [31:0] f;
      logic        uses_n;
      f      = '0;
      uses_n = (op >= OP_VADD) && (op <= OP_VNMLS);
      if (dbl) begin
        f         = SZ_BIT;
        f[22]     = d[4];
        f[15:12]  = d[3:0];
        if (op == OP_VMOV_IMM) begin
          f[19]    = imm[63];
          f[18]    = ~imm[62];
          f[17:16] = imm[53:52];
          f[3:0]   = imm[51:48];
        end else begin
          if (uses_n) begin
            f[7]     = n[4];
            f[19:16] = n[3:0];
          end
          f[5]   = m[4];
          f[3:0] = m[3:0];
        end
      end else begin
        f[15:12] = d[4:1];
        f[22]    = d[0];
        if (op == OP_VMOV_IMM) begin
          f[19]    = imm[31];
          f[18]    = ~imm[30];
          f[17:16] = imm[24:23];
          f[3:0]   = imm[22:19];
        end else begin
          if (uses_n) begin
            f[19:16] = n[4:1];
            f[7]     = n[0];
          end
          f[3:0] = m[4:1];
          f[5]   = m[0];
        end
      end
      return base_word(op) | f;
    endfunction

    function void note_instruction(input in_t item);
      logic [4:0] d;
      logic [4:0] n;
      logic [4:0] m;
      logic [4:0] bank;
      logic [4:0] wrap;
      logic [4:0] step;
      logic [4:0] m_step;
      logic [3:0] len;
      out_t       word;
      if (item.op_code >= NUM_OPS) return;
      bank   = item.double_precision ? BANK_MASK_DP : BANK_MASK_SP;
      wrap   = item.double_precision ? WRAP_MASK_DP : WRAP_MASK_SP;
      len    = (item.vector_length > MAX_LEN) ? 4'(MAX_LEN) : item.vector_length;
      d      = item.d_reg;
      n      = item.n_reg;
      m      = item.m_reg;
      step   = {3'b000, item.vector_stride};
      m_step = ((m & bank) == '0) ? '0 : step;
      for (int i = 0; i < len; i++) begin
        word.instr_word    = encode(item.op_code, item.double_precision, d, n, m,
                                    item.imm_bits);
        word.element_index = 3'(i);
        word.last          = (i == len - 1);
        expected_words.push_back(word);
        d = ((d + step) & wrap) | (d & bank);
        n = ((n + step) & wrap) | (n & bank);
        m = ((m + m_step) & wrap) | (m & bank);
      end
      element_count = len;
      current_d     = d;
      current_n     = n;
      current_m     = m;
    endfunction

    task check_result(input out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h with nothing expected", got.instr_word));
        return;
      end
      want = expected_words.pop_front();
      if (got.instr_word !== want.instr_word)
        report($sformatf("instr_word %h, expected %h", got.instr_word, want.instr_word));
      if (got.element_index !== want.element_index)
        report($sformatf("element_index %0d, expected %0d",
                         got.element_index, want.element_index));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b on word %h",
                         got.last, want.last, want.instr_word));
    endtask
  endclass

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  int unsigned cycle_count = 0;

  scalar_word_tracker sb;

  vfp_short_vector_expander DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vfp_short_vector_expander_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic in_t make_item(input logic [3:0] op, input logic dbl,
                                    input logic [4:0] d, input logic [4:0] n,
                                    input logic [4:0] m, input logic [3:0] len,
                                    input logic [1:0] stride, input logic [63:0] imm);
    in_t item;
    item.op_code          = op;
    item.double_precision = dbl;
    item.d_reg            = d;
    item.n_reg            = n;
    item.m_reg            = m;
    item.vector_length    = len;
    item.vector_stride    = stride;
    item.imm_bits         = imm;
    return item;
  endfunction

  task automatic send(input in_t item);
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_instruction(item);
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_words();
    start <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_t         directed_items[$];
    in_t         item;
    int unsigned sent;
    int unsigned r;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items.push_back(make_item(OP_VMOV, 0, 0, 0, 0, 1, 1, '0));
    directed_items.push_back(make_item(OP_VMOV, 1, 31, 31, 31, 8, 2, '1));
    directed_items.push_back(make_item(OP_VMOV_IMM, 0, 5, 0, 0, 3, 1,
                                       64'h0000_0000_FFFF_FFFF));
    directed_items.push_back(make_item(OP_VMOV_IMM, 0, 30, 31, 31, 2, 2,
                                       64'hFFFF_FFFF_4000_0000));
    directed_items.push_back(make_item(OP_VMOV_IMM, 1, 17, 0, 0, 4, 1, '1));
    directed_items.push_back(make_item(OP_VMOV_IMM, 1, 2, 0, 0, 2, 2, '0));
    directed_items.push_back(make_item(OP_VMOV_IMM, 1, 31, 5, 9, 1, 1,
                                       64'h4000_0000_0000_0000));
    directed_items.push_back(make_item(OP_VADD, 0, 9, 17, 25, 8, 1, '0));
    directed_items.push_back(make_item(OP_VSUB, 1, 4, 8, 12, 4, 2, '0));
    directed_items.push_back(make_item(OP_VDIV, 0, 31, 31, 31, 5, 2, '1));
    directed_items.push_back(make_item(OP_VMUL, 1, 0, 1, 2, 3, 1, '0));
    directed_items.push_back(make_item(OP_VNMUL, 0, 16, 24, 8, 7, 1, '0));
    directed_items.push_back(make_item(OP_VMLA, 1, 28, 20, 16, 6, 2, '0));
    directed_items.push_back(make_item(OP_VNMLA, 0, 12, 13, 14, 2, 1, '0));
    directed_items.push_back(make_item(OP_VMLS, 1, 7, 9, 11, 8, 1, '0));
    directed_items.push_back(make_item(OP_VNMLS, 0, 1, 2, 3, 4, 2, '0));
    directed_items.push_back(make_item(OP_VABS, 1, 10, 0, 2, 4, 1, '0));
    directed_items.push_back(make_item(OP_VNEG, 0, 8, 0, 15, 8, 2, '0));
    directed_items.push_back(make_item(OP_VSQRT, 1, 31, 0, 31, 3, 1, '0));
    directed_items.push_back(make_item(NUM_OPS, 0, 3, 4, 5, 5, 1, '1));
    directed_items.push_back(make_item(NUM_OPS + 4'd1, 1, 3, 4, 5, 8, 2, '1));
    directed_items.push_back(make_item(OP_VADD, 1, 6, 7, 8, 0, 1, '0));
    directed_items.push_back(make_item(OP_VMUL, 1, 13, 21, 29, 15, 1, '0));
    directed_items.push_back(make_item(OP_VSUB, 0, 19, 20, 21, 4, 0, '0));
    directed_items.push_back(make_item(OP_VMLA, 0, 13, 22, 30, 8, 3, '0));
    directed_items.push_back(make_item(OP_VNMLA, 1, 13, 22, 30, 8, 3, '0));

    foreach (directed_items[i]) begin
      send(directed_items[i]);
      maybe_idle(1'b1);
    end
    drain_words();
    @(posedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      item.op_code = (r == 0) ? NUM_OPS + 4'($urandom_range(0, 1))
                              : 4'($urandom_range(0, NUM_OPS - 1));
      item.double_precision = 1'($urandom_range(0, 1));
      item.d_reg            = 5'($urandom);
      item.n_reg            = 5'($urandom);
      item.m_reg            = 5'($urandom);
      r = $urandom_range(0, 19);
      item.vector_length = (r < 2) ? 4'd0 :
                           (r < 4) ? 4'($urandom_range(9, 15)) :
                                     4'($urandom_range(1, MAX_LEN));
      item.vector_stride = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 1) * 3)
                                                      : 2'($urandom_range(1, 2));
      item.imm_bits = {$urandom, $urandom};
      send(item);
      sent++;
      if (sent == RANDOM_ITEMS / 2) begin
        drain_words();
        @(posedge clk);
      end else begin
        maybe_idle(sent < RANDOM_ITEMS - QUIET_TAIL);
      end
    end

    drain_words();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0)
      $display("vfp_short_vector_expander_test: clean");
    else
      $display("vfp_short_vector_expander_test: errors");
    $finish;
  end

endmodule
